// ----- sv/hhnc_pkg.sv -----
package hhnc_pkg;

	localparam int unsigned TABLE_ENTRIES = 47;
	localparam int unsigned NUM_NAMES_DEF = 47;
	localparam int unsigned NAME_MAX_LEN = 19;
	localparam int unsigned NAME_BITS = NAME_MAX_LEN * 8;
	localparam int unsigned POS_W = 5;
	localparam int unsigned INDEX_W = 6;

	localparam logic [POS_W-1:0] POS_MAX = 5'd31;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_TAB = 8'h09;

	// Names are right-justified: the final character sits in bits [7:0].
	localparam logic [NAME_BITS-1:0] NAME_TXT [TABLE_ENTRIES] = '{
		"Accept", "Accept-Charset", "Accept-Encoding", "Accept-Language",
		"Accept-Ranges", "Age", "Allow", "Authorization", "Cache-Control",
		"Connection", "Content-Encoding", "Content-Language", "Content-Length",
		"Content-Location", "Content-MD5", "Content-Range", "Content-Type",
		"Date", "ETag", "Expect", "Expires", "From", "Host", "If-Match",
		"If-Modified-Since", "If-None-Match", "If-Range", "If-Unmodified-Since",
		"Last-Modified", "Location", "Max-Forwards", "Pragma",
		"Proxy-Authenticate", "Proxy-Authorization", "Range", "Referer",
		"Retry-After", "Server", "TE", "Trailer", "Transfer-Encoding",
		"Upgrade", "User-Agent", "Vary", "Via", "Warning", "WWW-Authenticate"
	};

	localparam logic [POS_W-1:0] NAME_LEN [TABLE_ENTRIES] = '{
		5'd6, 5'd14, 5'd15, 5'd15,
		5'd13, 5'd3, 5'd5, 5'd13, 5'd13,
		5'd10, 5'd16, 5'd16, 5'd14,
		5'd16, 5'd11, 5'd13, 5'd12,
		5'd4, 5'd4, 5'd6, 5'd7, 5'd4, 5'd4, 5'd8,
		5'd17, 5'd13, 5'd8, 5'd19,
		5'd13, 5'd8, 5'd12, 5'd6,
		5'd18, 5'd19, 5'd5, 5'd7,
		5'd11, 5'd6, 5'd2, 5'd7, 5'd17,
		5'd7, 5'd10, 5'd4, 5'd3, 5'd7, 5'd16
	};

	typedef struct packed {
		logic [7:0] name_char;
		logic       last_char;
	} char_item_t;

	typedef struct packed {
		logic               found;
		logic [INDEX_W-1:0] name_index;
	} result_item_t;

	// Item as it moves along the cell chain.
	typedef struct packed {
		logic               vld;
		logic               last;
		logic               name_ch;
		logic [7:0]         ch;
		logic [POS_W-1:0]   pos;
		logic [POS_W-1:0]   len;
		logic               hit;
		logic [INDEX_W-1:0] idx;
	} chain_item_t;

	function automatic logic [7:0] lower_byte(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic [7:0] entry_byte(input int unsigned idx,
			input logic [POS_W-1:0] pos);
		logic [NAME_BITS-1:0] txt;
		logic [POS_W-1:0]     len;
		logic [POS_W-1:0]     sh;
		logic [7:0]           r;
		txt = NAME_TXT[idx];
		len = NAME_LEN[idx];
		sh = len - 5'd1 - pos;
		r = 8'h00;
		if (pos < len) begin
			r = lower_byte(txt[{sh, 3'b000} +: 8]);
		end
		return r;
	endfunction

endpackage

// ----- sv/hhnc_head.sv -----
module hhnc_head (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    char_valid,
	input  hhnc_pkg::char_item_t    char_data,
	output hhnc_pkg::chain_item_t   item
);

	logic [hhnc_pkg::POS_W-1:0] pos_q;
	logic                       ended_q;
	logic                       delim;
	logic                       name_ch;
	logic [hhnc_pkg::POS_W-1:0] len_after;
	logic                       take;

	assign take = char_valid && advance;

	always_comb begin
		delim = (char_data.name_char == hhnc_pkg::CHAR_SPACE) ||
			(char_data.name_char == hhnc_pkg::CHAR_COLON) ||
			(char_data.name_char == hhnc_pkg::CHAR_TAB);
		name_ch = !ended_q && !delim;
		len_after = pos_q;
		if (name_ch && pos_q != hhnc_pkg::POS_MAX) begin
			len_after = pos_q + 5'd1;
		end
		item.vld = char_valid;
		item.last = char_data.last_char;
		item.name_ch = name_ch;
		item.ch = hhnc_pkg::lower_byte(char_data.name_char);
		item.pos = pos_q;
		item.len = len_after;
		item.hit = 1'b0;
		item.idx = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ended_q <= 1'b0;
		end else if (take) begin
			if (char_data.last_char) begin
				pos_q <= '0;
				ended_q <= 1'b0;
			end else begin
				pos_q <= len_after;
				ended_q <= ended_q || delim;
			end
		end
	end

`ifndef SYNTH
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && char_data.last_char |=> pos_q == '0 && !ended_q)
		else $error("name state not cleared after last item");
	a_ended_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && ended_q && !char_data.last_char |=> pos_q == $past(pos_q) && ended_q)
		else $error("position moved after delimiter");
`endif

endmodule

// ----- sv/hhnc_cell.sv -----
module hhnc_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  hhnc_pkg::chain_item_t prev,
	output hhnc_pkg::chain_item_t next
);

	logic                  cand_q;
	logic                  cand_after;
	logic                  hit_here;
	hhnc_pkg::chain_item_t item_s1;
	hhnc_pkg::chain_item_t item_d;

	always_comb begin
		cand_after = cand_q;
		if (prev.name_ch) begin
			cand_after = cand_q && (prev.pos < hhnc_pkg::NAME_LEN[IDX]) &&
				(prev.ch == hhnc_pkg::entry_byte(IDX, prev.pos));
		end
		hit_here = cand_after && (prev.len == hhnc_pkg::NAME_LEN[IDX]);
		item_d = prev;
		// Lower cells win: keep an earlier hit.
		if (prev.last && !prev.hit && hit_here) begin
			item_d.hit = 1'b1;
			item_d.idx = hhnc_pkg::INDEX_W'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b1;
			item_s1 <= '0;
		end else if (advance) begin
			item_s1 <= item_d;
			if (prev.vld) begin
				cand_q <= prev.last ? 1'b1 : cand_after;
			end
		end
	end

	assign next = item_s1;

endmodule

// ----- sv/http_header_name_classifier.sv -----
// Channel  Signals                                  Item
// char     char_valid, char_stall, char_data        name_char, last_char
// result   result_valid, result_stall, result_data  found, name_index
//
// One character item per cycle while char_stall is low; result_valid rises after its
// last character has passed one cell per used table entry and the result register.
// Only items with last_char set give a result.
// Reset clears the name state and all chain valids and sets the candidate bits.
// A stalled result freezes the whole chain, and char_stall follows it.
module http_header_name_classifier #(
	parameter int unsigned NUM_NAMES = hhnc_pkg::NUM_NAMES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  hhnc_pkg::char_item_t   char_data,
	output logic                   result_valid,
	input  logic                   result_stall,
	output hhnc_pkg::result_item_t result_data
);

	localparam int unsigned NUM_CELLS = (NUM_NAMES < hhnc_pkg::TABLE_ENTRIES) ?
		NUM_NAMES : hhnc_pkg::TABLE_ENTRIES;

	logic                   advance;
	logic                   result_valid_q;
	hhnc_pkg::result_item_t result_q;
	hhnc_pkg::chain_item_t  chain [NUM_CELLS+1];

	assign advance = !result_valid_q || !result_stall;
	assign char_stall = !advance;

	hhnc_head u_head (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.char_valid (char_valid),
		.char_data  (char_data),
		.item       (chain[0])
	);

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		hhnc_cell #(
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.prev    (chain[i]),
			.next    (chain[i+1])
		);
	end

	// Drop non-final items at the end of the chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			result_q <= '0;
		end else if (advance) begin
			result_valid_q <= chain[NUM_CELLS].vld && chain[NUM_CELLS].last;
			result_q.found <= chain[NUM_CELLS].hit;
			result_q.name_index <= chain[NUM_CELLS].idx;
		end
	end

	assign result_valid = result_valid_q;
	assign result_data = result_q;

`ifndef SYNTH
	a_miss_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_data.found |-> result_data.name_index == '0)
		else $error("nonzero index on a miss");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.found |->
		result_data.name_index < hhnc_pkg::INDEX_W'(NUM_CELLS))
		else $error("index beyond table");
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		char_stall |-> result_valid && result_stall)
		else $error("input stalled without a held result");
`endif

endmodule
